// ----- rtl/tccw_pkg.sv -----
// shared types and constants for the text console cell writer
package tccw_pkg;

    localparam int CELL_INDEX_W = 11;
    localparam int CURSOR_W     = 11;
    localparam int CELL_W       = 16;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [7:0]  CH_BS        = 8'd8;
    localparam logic [7:0]  CH_TAB       = 8'd9;
    localparam logic [7:0]  CH_LF        = 8'd10;
    localparam logic [7:0]  CH_CR        = 8'd13;
    localparam logic [7:0]  CH_SPACE     = 8'h20;
    localparam logic [7:0]  DEFAULT_ATTR = 8'h07;
    localparam logic [15:0] BLANK_CELL   = 16'h0720;

    localparam logic [2:0]  TAB_SPACES   = 3'd5;

    typedef struct packed {
        logic                    cmd;
        logic [7:0]              char_code;
        logic [7:0]              attribute;
        logic [CELL_INDEX_W-1:0] cell_index;
    } t_in;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_loc;
        logic [CELL_W-1:0]   read_data;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd_cell;
        logic finish;
        logic tab_load;
        logic put_exec;
        logic scr_rd;
        logic scr_wr;
        logic blank_wr;
        logic idx_clr;
        logic scroll_done;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic eff_is_tab;
        logic need_scroll;
        logic tab_pending;
        logic copy_last;
        logic blank_last;
    } t_sts;

endpackage

// ----- rtl/tccw_dp.sv -----
// datapath: screen memory, cursor and column, scroll index, result register
module tccw_dp import tccw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_item,
    input  t_ctl i_ctl,
    output t_sts o_sts,
    output logic o_strobe,
    output t_out o_result
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);
    localparam int CLW   = $clog2(COLUMNS);
    localparam int IXW   = (CW > CELL_INDEX_W) ? CW : CELL_INDEX_W;

    logic [CELL_W-1:0] r_mem [CELLS];
    logic [CELL_W-1:0] r_q;

    t_in             r_item;
    logic [CW-1:0]   r_cursor, n_cursor;
    logic [CLW-1:0]  r_col, n_col;
    logic [2:0]      r_tab_left, n_tab_left;
    logic [AW-1:0]   r_idx, n_idx;
    logic            r_strobe;
    t_out            r_result;

    logic [7:0]        eff_char;
    logic [7:0]        eff_attr;
    logic [CW-1:0]     op_cursor;
    logic [CLW-1:0]    op_col;
    logic              put_we;
    logic [AW-1:0]     put_addr;
    logic [CELL_W-1:0] put_data;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic              in_range;

    // tab expands into plain spaces with the default attribute
    always_comb begin
        if (r_tab_left != 3'd0) begin
            eff_char = CH_SPACE;
            eff_attr = DEFAULT_ATTR;
        end else begin
            eff_char = r_item.char_code;
            eff_attr = (r_item.attribute == 8'd0) ? DEFAULT_ATTR : r_item.attribute;
        end
    end

    // one put: cursor and column move, at most one cell written
    always_comb begin
        op_cursor = r_cursor;
        op_col    = r_col;
        put_we    = 1'b0;
        put_addr  = AW'(r_cursor);
        put_data  = {eff_attr, eff_char};
        case (eff_char)
            CH_BS: begin
                if (r_cursor != '0) begin
                    op_cursor = r_cursor - CW'(1);
                    op_col    = (r_col == '0) ? CLW'(COLUMNS - 1) : r_col - CLW'(1);
                    put_we    = 1'b1;
                    put_addr  = AW'(r_cursor - CW'(1));
                    put_data  = {eff_attr, CH_SPACE};
                end
            end
            CH_LF: begin
                op_cursor = r_cursor - CW'(r_col) + CW'(COLUMNS);
                op_col    = '0;
            end
            CH_CR: begin
                op_cursor = r_cursor - CW'(r_col);
                op_col    = '0;
            end
            default: begin
                put_we    = 1'b1;
                op_cursor = r_cursor + CW'(1);
                op_col    = (r_col == CLW'(COLUMNS - 1)) ? '0 : r_col + CLW'(1);
            end
        endcase
    end

    always_comb begin
        n_cursor = r_cursor;
        n_col    = r_col;
        if (i_ctl.put_exec) begin
            n_cursor = op_cursor;
            n_col    = op_col;
        end else if (i_ctl.scroll_done) begin
            n_cursor = r_cursor - CW'(COLUMNS);
        end

        n_tab_left = r_tab_left;
        if (i_ctl.tab_load) begin
            n_tab_left = TAB_SPACES;
        end else if (i_ctl.put_exec && r_tab_left != 3'd0) begin
            n_tab_left = r_tab_left - 3'd1;
        end

        n_idx = r_idx;
        if (i_ctl.idx_clr) begin
            n_idx = '0;
        end else if (i_ctl.scr_wr || i_ctl.blank_wr) begin
            n_idx = r_idx + AW'(1);
        end
    end

    // memory port muxing
    always_comb begin
        mem_we    = (i_ctl.put_exec && put_we) || i_ctl.scr_wr || i_ctl.blank_wr;
        mem_waddr = i_ctl.put_exec ? put_addr : r_idx;
        if (i_ctl.put_exec) begin
            mem_wdata = put_data;
        end else if (i_ctl.scr_wr) begin
            mem_wdata = r_q;
        end else begin
            mem_wdata = BLANK_CELL;
        end
        mem_re    = i_ctl.rd_cell || i_ctl.scr_rd;
        mem_raddr = i_ctl.rd_cell ? AW'(r_item.cell_index)
                                  : AW'(CW'(r_idx) + CW'(COLUMNS));
    end

    assign in_range = IXW'(r_item.cell_index) < IXW'(CELLS);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_q <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_item <= i_item;
        end
        if (i_ctl.finish) begin
            r_result.cursor_loc <= CURSOR_W'(r_cursor);
            r_result.read_data  <= (r_item.cmd == CMD_READ && in_range) ? r_q : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor   <= '0;
            r_col      <= '0;
            r_tab_left <= '0;
            r_idx      <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_cursor   <= n_cursor;
            r_col      <= n_col;
            r_tab_left <= n_tab_left;
            r_idx      <= n_idx;
            r_strobe   <= i_ctl.finish;
        end
    end

    assign o_sts.eff_is_tab  = (eff_char == CH_TAB);
    assign o_sts.need_scroll = (r_cursor >= CW'(CELLS));
    assign o_sts.tab_pending = (r_tab_left != 3'd0);
    assign o_sts.copy_last   = (r_idx == AW'(CELLS - COLUMNS - 1));
    assign o_sts.blank_last  = (r_idx == AW'(CELLS - 1));

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ----- rtl/tccw_ctrl.sv -----
// controller: sequences clear pass, puts, tab expansion, scroll and reads
module tccw_ctrl import tccw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_is_read,
    input  t_sts i_sts,
    output logic o_busy,
    output t_ctl o_ctl
);

    typedef enum logic [8:0] {
        S_CLEAR     = 9'b000000001,
        S_IDLE      = 9'b000000010,
        S_READ      = 9'b000000100,
        S_PUT       = 9'b000001000,
        S_CHK       = 9'b000010000,
        S_SCR_RD    = 9'b000100000,
        S_SCR_WR    = 9'b001000000,
        S_SCR_BLANK = 9'b010000000,
        S_FINISH    = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_CLEAR: begin
                o_ctl.blank_wr = 1'b1;
                if (i_sts.blank_last) begin
                    o_ctl.idx_clr = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = i_is_read ? S_READ : S_PUT;
                end
            end
            S_READ: begin
                o_ctl.rd_cell = 1'b1;
                n_state       = S_FINISH;
            end
            S_PUT: begin
                if (i_sts.eff_is_tab) begin
                    o_ctl.tab_load = 1'b1;
                end else begin
                    o_ctl.put_exec = 1'b1;
                    n_state        = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.need_scroll) begin
                    n_state = S_SCR_RD;
                end else if (i_sts.tab_pending) begin
                    n_state = S_PUT;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SCR_RD: begin
                o_ctl.scr_rd = 1'b1;
                n_state      = S_SCR_WR;
            end
            S_SCR_WR: begin
                o_ctl.scr_wr = 1'b1;
                n_state      = i_sts.copy_last ? S_SCR_BLANK : S_SCR_RD;
            end
            S_SCR_BLANK: begin
                o_ctl.blank_wr = 1'b1;
                if (i_sts.blank_last) begin
                    o_ctl.idx_clr     = 1'b1;
                    o_ctl.scroll_done = 1'b1;
                    n_state           = S_CHK;
                end
            end
            S_FINISH: begin
                o_ctl.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- rtl/text_console_cell_writer_top.sv -----
// top level of the text console cell writer
//
//  channel   signals               transfer
//  input     start, busy, i_item   rising edge with start high and busy low
//  result    o_strobe, o_result    the one cycle o_strobe is high
//
// a read passes through the read and finish states, a plain put or control code
// through the put, check and finish states; busy drops as o_strobe rises, so a
// new item is taken only once the last is done. a tab first loads its count, then
// runs five spaces, each through the put and check states. a scroll copies each
// cell up a row via a read and a write state, blanks the bottom row one cell a
// cycle and rechecks once. after reset busy stays high while all cells are blanked.
// results cannot be held off; busy is the only stall, on the input side.
module text_console_cell_writer_top import tccw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output logic o_strobe,
    output t_out o_result
);

    t_ctl ctl;
    t_sts sts;

    tccw_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_is_read (i_item.cmd == CMD_READ),
        .i_sts     (sts),
        .o_busy    (busy),
        .o_ctl     (ctl)
    );

    tccw_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_ctl    (ctl),
        .o_sts    (sts),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule
